[rtl/core/qls_pkg.sv]
// ----------------------------------------------------------------------------
// qls_pkg
// Shared types and constants of the Q-learning slot selector.
// ----------------------------------------------------------------------------
package qls_pkg;

	localparam int MAX_SLOTS_DEF = 64;

	localparam int Q_W    = 32;
	localparam int K_W    = 4;
	localparam int SLOT_W = 6;
	localparam int DRAW_W = 16;
	localparam int GAIN_W = 17;
	localparam int THR_W  = 16;
	localparam int SIU_W  = 7;
	localparam int OUTC_W = 2;
	localparam int CFG_W  = 17;
	localparam int CFG_IDX_W = 2;

	// dividend width of the shared remainder unit
	localparam int DIV_W = 16;

	localparam logic [SIU_W-1:0]  SLOTS_RST = 7'd40;
	localparam logic [GAIN_W-1:0] GAIN_RST  = 17'd65536;
	localparam logic [THR_W-1:0]  THR_RST   = 16'd655;
	localparam logic [K_W-1:0]    KLIM_RST  = 4'd14;

	localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

	localparam logic [OUTC_W-1:0] OUTC_SUCCESS   = 2'd1;
	localparam logic [OUTC_W-1:0] OUTC_COLLISION = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SLOTS_IN_USE,
		CFG_GAIN,
		CFG_EXPLORE_THR,
		CFG_K_LIMIT
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_RMOD,
		ST_SCAN,
		ST_TMOD,
		ST_PICK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic           en;
		logic [Q_W-1:0] q;
		logic [K_W-1:0] k;
	} mem_wr_t;

endpackage

[rtl/core/qls_slot_mem.sv]
// ----------------------------------------------------------------------------
// qls_slot_mem
// Per-slot Q and K storage: one write port, one registered read port, and a
// valid bit per entry so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module qls_slot_mem #(
	parameter int MAX_SLOTS = qls_pkg::MAX_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [$clog2(MAX_SLOTS)-1:0]     rd_addr,
	input  logic [$clog2(MAX_SLOTS)-1:0]     wr_addr,
	input  qls_pkg::mem_wr_t                 wr,
	output logic signed [qls_pkg::Q_W-1:0]   rd_q,
	output logic [qls_pkg::K_W-1:0]          rd_k
);

	logic [qls_pkg::Q_W-1:0] q_mem [MAX_SLOTS];
	logic [qls_pkg::K_W-1:0] k_mem [MAX_SLOTS];
	logic [MAX_SLOTS-1:0]    valid_q;
	logic [qls_pkg::Q_W-1:0] rd_q_q;
	logic [qls_pkg::K_W-1:0] rd_k_q;
	logic                    rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			q_mem[wr_addr] <= wr.q;
			k_mem[wr_addr] <= wr.k;
		end
		rd_q_q <= q_mem[rd_addr];
		rd_k_q <= k_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign rd_q = rd_valid_q ? $signed(rd_q_q) : '0;
	assign rd_k = rd_valid_q ? rd_k_q : '0;

endmodule

[rtl/core/qls_mod_unit.sv]
// ----------------------------------------------------------------------------
// qls_mod_unit
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module qls_mod_unit #(
	parameter int DVSR_W = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [qls_pkg::DIV_W-1:0]   dividend,
	input  logic [DVSR_W-1:0]           divisor,
	output logic                        done,
	output logic [DVSR_W-1:0]           remainder
);

	localparam int CNT_BITS = $clog2(qls_pkg::DIV_W + 1);

	logic [qls_pkg::DIV_W-1:0] dvd_q;
	logic [DVSR_W-1:0]         dvsr_q;
	logic [DVSR_W-1:0]         rem_q;
	logic [CNT_BITS-1:0]       cnt_q;
	logic                      run_q;
	logic                      done_q;
	logic [DVSR_W:0]           trial;
	logic [DVSR_W:0]           diff;

	// remainder stays below the divisor, so trial is below twice the divisor
	assign trial = {rem_q, dvd_q[qls_pkg::DIV_W-1]};
	assign diff  = trial - {1'b0, dvsr_q};

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dividend;
			dvsr_q <= divisor;
			rem_q  <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[qls_pkg::DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, dvsr_q}) begin
				rem_q <= diff[DVSR_W-1:0];
			end else begin
				rem_q <= trial[DVSR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == CNT_BITS'(1));
			if (start) begin
				cnt_q <= CNT_BITS'(qls_pkg::DIV_W);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

[rtl/core/q_learning_slot_selector_core.sv]
// ----------------------------------------------------------------------------
// q_learning_slot_selector_core
// Q-learning slot chooser for framed slotted ALOHA, one node.
// ----------------------------------------------------------------------------
// One frame outcome is taken when start is high and busy is low; busy stays
// high until the result strobe done, which holds next_slot, explored and
// updated_q for exactly one cycle and cannot be held off by the receiver.
// An item begins with the Q/K read-modify-write of the current slot, then
// takes either the exploration remainder (random_slot modulo S), or a scan
// of S slots, a tie remainder and a second scan that stops at the chosen
// tied slot; it ends with a result state and an idle state in which the next
// item is accepted. S is the number of slots in use. The item time is set
// by the single read port of the slot memory, read at most once per slot in
// each scan, and the bit-serial remainder unit. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module q_learning_slot_selector_core #(
	parameter int MAX_SLOTS = qls_pkg::MAX_SLOTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [qls_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [qls_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               start,
	output logic                               busy,
	input  logic [qls_pkg::OUTC_W-1:0]         outcome,
	input  logic [qls_pkg::DRAW_W-1:0]         explore_draw,
	input  logic [qls_pkg::SLOT_W-1:0]         random_slot,
	input  logic [qls_pkg::DRAW_W-1:0]         tie_pick,
	output logic                               done,
	output logic [qls_pkg::SLOT_W-1:0]         next_slot,
	output logic                               explored,
	output logic signed [qls_pkg::Q_W-1:0]     updated_q
);

	localparam int IDX_W = $clog2(MAX_SLOTS);
	localparam int CNT_W = $clog2(MAX_SLOTS + 1);
	localparam int Q_W   = qls_pkg::Q_W;
	localparam int K_W   = qls_pkg::K_W;

	qls_pkg::state_t state_q, state_d;

	logic [qls_pkg::SIU_W-1:0]  slots_in_use_q;
	logic [qls_pkg::GAIN_W-1:0] gain_q;
	logic [qls_pkg::THR_W-1:0]  thr_q;
	logic [K_W-1:0]             k_limit_q;

	logic [qls_pkg::OUTC_W-1:0] outcome_q;
	logic [qls_pkg::DRAW_W-1:0] draw_q;
	logic [qls_pkg::SLOT_W-1:0] rslot_q;
	logic [qls_pkg::DRAW_W-1:0] tie_q;
	logic [qls_pkg::SLOT_W-1:0] cur_q;

	logic [CNT_W-1:0]       issue_q;
	logic                   rvalid_s1;
	logic [IDX_W-1:0]       ridx_s1;
	logic signed [Q_W-1:0]  best_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       rank_q;
	logic [CNT_W-1:0]       seen_q;
	logic [IDX_W-1:0]       next_q;
	logic                   explored_q;
	logic signed [Q_W-1:0]  updated_q_q;

	logic [CNT_W-1:0]       eff_slots;
	logic [IDX_W-1:0]       cur_idx;
	logic [IDX_W-1:0]       rd_addr;
	qls_pkg::mem_wr_t       mem_wr;
	logic signed [Q_W-1:0]  rd_q;
	logic [K_W-1:0]         rd_k;

	logic                   upd;
	logic                   explore;
	logic [Q_W-1:0]         delta;
	logic signed [Q_W+1:0]  sum;
	logic [Q_W-1:0]         new_q;
	logic [K_W:0]           k_inc;
	logic [K_W-1:0]         new_k;

	logic                   issue_now;
	logic                   scan_end;
	logic                   pick_hit;

	logic                     div_start;
	logic [qls_pkg::DIV_W-1:0] div_dividend;
	logic [CNT_W-1:0]         div_divisor;
	logic                     div_done;
	logic [CNT_W-1:0]         div_rem;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_in_use_q <= qls_pkg::SLOTS_RST;
			gain_q         <= qls_pkg::GAIN_RST;
			thr_q          <= qls_pkg::THR_RST;
			k_limit_q      <= qls_pkg::KLIM_RST;
		end else if (cfg_we) begin
			unique case (qls_pkg::cfg_idx_t'(cfg_index))
				qls_pkg::CFG_SLOTS_IN_USE: slots_in_use_q <= cfg_data[qls_pkg::SIU_W-1:0];
				qls_pkg::CFG_GAIN:         gain_q         <= cfg_data[qls_pkg::GAIN_W-1:0];
				qls_pkg::CFG_EXPLORE_THR:  thr_q          <= cfg_data[qls_pkg::THR_W-1:0];
				qls_pkg::CFG_K_LIMIT:      k_limit_q      <= cfg_data[K_W-1:0];
			endcase
		end
	end

	// clamp slot count into [2, MAX_SLOTS]
	always_comb begin
		if (slots_in_use_q < 7'd2) begin
			eff_slots = CNT_W'(2);
		end else if (int'(slots_in_use_q) > MAX_SLOTS) begin
			eff_slots = CNT_W'(MAX_SLOTS);
		end else begin
			eff_slots = CNT_W'(slots_in_use_q);
		end
	end

	// ---------------- update arithmetic ----------------
	assign cur_idx = IDX_W'(cur_q);
	assign upd     = (outcome_q == qls_pkg::OUTC_SUCCESS) ||
	                 (outcome_q == qls_pkg::OUTC_COLLISION);
	assign explore = (outcome_q == qls_pkg::OUTC_COLLISION) && (draw_q < thr_q);
	assign delta   = {{(Q_W - qls_pkg::GAIN_W){1'b0}}, gain_q} << rd_k;

	always_comb begin
		if (outcome_q == qls_pkg::OUTC_SUCCESS) begin
			sum = $signed({{2{rd_q[Q_W-1]}}, rd_q}) + $signed({2'b00, delta});
		end else begin
			sum = $signed({{2{rd_q[Q_W-1]}}, rd_q}) - $signed({2'b00, delta});
		end
		// saturate when the top three bits disagree
		if (sum[Q_W+1:Q_W-1] == 3'b000 || sum[Q_W+1:Q_W-1] == 3'b111) begin
			new_q = sum[Q_W-1:0];
		end else if (sum[Q_W+1]) begin
			new_q = qls_pkg::Q_MIN;
		end else begin
			new_q = qls_pkg::Q_MAX;
		end
		k_inc = {1'b0, rd_k} + (K_W+1)'(1);
		if (k_inc > {1'b0, k_limit_q}) begin
			new_k = k_limit_q;
		end else begin
			new_k = k_inc[K_W-1:0];
		end
	end

	always_comb begin
		mem_wr.en = (state_q == qls_pkg::ST_UPD_WR) && upd;
		mem_wr.q  = new_q;
		mem_wr.k  = new_k;
	end

	// ---------------- scan control ----------------
	assign issue_now = (issue_q < eff_slots) &&
	                   ((state_q == qls_pkg::ST_SCAN) || (state_q == qls_pkg::ST_PICK));
	assign scan_end  = (state_q == qls_pkg::ST_SCAN) && (issue_q == eff_slots) && !rvalid_s1;
	assign pick_hit  = (state_q == qls_pkg::ST_PICK) && rvalid_s1 && (rd_q == best_q) &&
	                   (seen_q == rank_q);
	assign rd_addr   = (state_q == qls_pkg::ST_UPD_RD) ? cur_idx : issue_q[IDX_W-1:0];

	qls_slot_mem #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.wr_addr (cur_idx),
		.wr      (mem_wr),
		.rd_q    (rd_q),
		.rd_k    (rd_k)
	);

	assign div_start    = ((state_q == qls_pkg::ST_UPD_WR) && explore) || scan_end;
	assign div_dividend = (state_q == qls_pkg::ST_UPD_WR) ?
	                      {{(qls_pkg::DIV_W - qls_pkg::SLOT_W){1'b0}}, rslot_q} : tie_q;
	assign div_divisor  = (state_q == qls_pkg::ST_UPD_WR) ? eff_slots : count_q;

	qls_mod_unit #(
		.DVSR_W (CNT_W)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.remainder (div_rem)
	);

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			qls_pkg::ST_IDLE:   if (start) state_d = qls_pkg::ST_UPD_RD;
			qls_pkg::ST_UPD_RD: state_d = qls_pkg::ST_UPD_WR;
			qls_pkg::ST_UPD_WR: state_d = explore ? qls_pkg::ST_RMOD : qls_pkg::ST_SCAN;
			qls_pkg::ST_RMOD:   if (div_done) state_d = qls_pkg::ST_DONE;
			qls_pkg::ST_SCAN:   if (scan_end) state_d = qls_pkg::ST_TMOD;
			qls_pkg::ST_TMOD:   if (div_done) state_d = qls_pkg::ST_PICK;
			qls_pkg::ST_PICK:   if (pick_hit) state_d = qls_pkg::ST_DONE;
			qls_pkg::ST_DONE:   state_d = qls_pkg::ST_IDLE;
			default:            state_d = qls_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != qls_pkg::ST_IDLE);
		done = (state_q == qls_pkg::ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= qls_pkg::ST_IDLE;
			cur_q     <= '0;
			issue_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rvalid_s1 <= issue_now;
			if (state_q == qls_pkg::ST_DONE) begin
				cur_q <= qls_pkg::SLOT_W'(next_q);
			end
			if ((state_q == qls_pkg::ST_UPD_WR) ||
			    ((state_q == qls_pkg::ST_TMOD) && div_done)) begin
				issue_q <= '0;
			end else if (issue_now) begin
				issue_q <= issue_q + CNT_W'(1);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		ridx_s1 <= issue_q[IDX_W-1:0];
		if ((state_q == qls_pkg::ST_IDLE) && start) begin
			outcome_q <= outcome;
			draw_q    <= explore_draw;
			rslot_q   <= random_slot;
			tie_q     <= tie_pick;
		end
		if (state_q == qls_pkg::ST_UPD_WR) begin
			updated_q_q <= upd ? $signed(new_q) : rd_q;
			explored_q  <= explore;
		end
		if ((state_q == qls_pkg::ST_RMOD) && div_done) begin
			next_q <= div_rem[IDX_W-1:0];
		end
		// running maximum and its tie count
		if ((state_q == qls_pkg::ST_SCAN) && rvalid_s1) begin
			if ((ridx_s1 == '0) || (rd_q > best_q)) begin
				best_q  <= rd_q;
				count_q <= CNT_W'(1);
			end else if (rd_q == best_q) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
		if ((state_q == qls_pkg::ST_TMOD) && div_done) begin
			rank_q <= div_rem;
			seen_q <= '0;
		end
		// walk tied slots in ascending order until the chosen rank
		if ((state_q == qls_pkg::ST_PICK) && rvalid_s1 && (rd_q == best_q)) begin
			if (seen_q == rank_q) begin
				next_q <= ridx_s1;
			end else begin
				seen_q <= seen_q + CNT_W'(1);
			end
		end
	end

	assign next_slot = qls_pkg::SLOT_W'(next_q);
	assign explored  = explored_q;
	assign updated_q = updated_q_q;

endmodule

[rtl/core/qls_checker.sv]
// ----------------------------------------------------------------------------
// qls_checker
// Port-level checks of the command handshake and result strobe.
// ----------------------------------------------------------------------------
module qls_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// an accepted command keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a busy period");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// the block is free again right after its result transfer
	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy held after result transfer");

endmodule

bind q_learning_slot_selector_core qls_checker u_qls_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
